>>> hdl/rgp_pkg.sv
// ----------------------------------------------------------------------------
// rgp_pkg: shared types and constants for the radial gradient pixel unit
// Word structs, register indexes and pipeline widths.
// ----------------------------------------------------------------------------
`default_nettype none
package rgp_pkg;
   localparam int CoordBits     = 12;
   localparam int FracBits      = 16;
   localparam int IntensityMax  = 255;
   localparam int SqBits        = 32;
   localparam int RootPairs     = SqBits / 2 + FracBits;   // 32 root bits
   localparam int RootBits      = RootPairs;
   localparam int RemBits       = RootBits + 2;
   localparam int RadBits       = 12;                      // r <= 4095
   localparam int QuoBits       = RootBits;                // quotient width
   localparam int SqrtCells     = RootPairs;
   localparam int DivCells      = QuoBits;

   localparam logic [2:0] RegLeft   = 3'd0;
   localparam logic [2:0] RegTop    = 3'd1;
   localparam logic [2:0] RegWidth  = 3'd2;
   localparam logic [2:0] RegHeight = 3'd3;
   localparam logic [2:0] RegMode   = 3'd4;

   typedef struct packed {
      logic [11:0] offset_x;
      logic [11:0] offset_y;
   } req_word_type;

   typedef struct packed {
      logic [12:0] screen_x;
      logic [12:0] screen_y;
      logic [6:0]  green_level;
      logic [7:0]  blue_level;
   } rsp_word_type;

   // side data riding along the pipeline with each pixel
   typedef struct packed {
      logic        valid;
      logic        zero_r;
      logic        mode;
      logic [12:0] screen_x;
      logic [12:0] screen_y;
   } side_type;
endpackage
`default_nettype wire

>>> hdl/rgp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rgp_sqrt_cell: one digit step of the restoring square root
// Consumes one bit pair of the scaled square and produces one root bit.
// ----------------------------------------------------------------------------
`default_nettype none
module rgp_sqrt_cell
   import rgp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire side_type              side_in,
   input  wire logic [SqBits-1:0]     sq_in,
   input  wire logic [RemBits-1:0]    rem_in,
   input  wire logic [RootBits-1:0]   root_in,
   input  wire logic [RadBits-1:0]    rad_in,
   output side_type                   side_out,
   output logic [SqBits-1:0]          sq_out,
   output logic [RemBits-1:0]         rem_out,
   output logic [RootBits-1:0]        root_out,
   output logic [RadBits-1:0]         rad_out
);
   side_type              side_ff;
   logic [SqBits-1:0]     sq_ff;
   logic [RemBits-1:0]    rem_ff, rem_sh, trial, rem_in_w;
   logic [RootBits-1:0]   root_ff, root_in_w;
   logic [RadBits-1:0]    rad_ff;

   // sq shifts left two bits per cell; its top pair is this digit
   always_comb begin
      rem_sh = {rem_in[RemBits-3:0], sq_in[SqBits-1 -: 2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
         rem_in_w  = rem_sh - trial;
         root_in_w = {root_in[RootBits-2:0], 1'b1};
      end else begin
         rem_in_w  = rem_sh;
         root_in_w = {root_in[RootBits-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff.valid <= side_in.valid;
      end
      side_ff.zero_r   <= side_in.zero_r;
      side_ff.mode     <= side_in.mode;
      side_ff.screen_x <= side_in.screen_x;
      side_ff.screen_y <= side_in.screen_y;
      sq_ff   <= {sq_in[SqBits-3:0], 2'b00};
      rem_ff  <= rem_in_w;
      root_ff <= root_in_w;
      rad_ff  <= rad_in;
   end

   assign side_out = side_ff;
   assign sq_out   = sq_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign rad_out  = rad_ff;
endmodule
`default_nettype wire

>>> hdl/rgp_div_cell.sv
// ----------------------------------------------------------------------------
// rgp_div_cell: one step of the restoring divide root / radius
// Brings in one dividend bit and produces one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none
module rgp_div_cell
   import rgp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire side_type              side_in,
   input  wire logic [RootBits-1:0]   num_in,
   input  wire logic [RadBits:0]      rem_in,
   input  wire logic [RadBits-1:0]    rad_in,
   output side_type                   side_out,
   output logic [RootBits-1:0]        num_out,
   output logic [RadBits:0]           rem_out,
   output logic [RadBits-1:0]         rad_out
);
   side_type             side_ff;
   logic [RootBits-1:0]  num_ff, num_in_w;
   logic [RadBits:0]     rem_ff, rem_in_w, rem_sh;
   logic [RadBits-1:0]   rad_ff;

   // num holds remaining dividend bits high, quotient bits enter low
   always_comb begin
      rem_sh = {rem_in[RadBits-1:0], num_in[RootBits-1]};
      if (rem_sh >= {1'b0, rad_in}) begin
         rem_in_w = rem_sh - {1'b0, rad_in};
         num_in_w = {num_in[RootBits-2:0], 1'b1};
      end else begin
         rem_in_w = rem_sh;
         num_in_w = {num_in[RootBits-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff.valid <= side_in.valid;
      end
      side_ff.zero_r   <= side_in.zero_r;
      side_ff.mode     <= side_in.mode;
      side_ff.screen_x <= side_in.screen_x;
      side_ff.screen_y <= side_in.screen_y;
      num_ff <= num_in_w;
      rem_ff <= rem_in_w;
      rad_ff <= rad_in;
   end

   assign side_out = side_ff;
   assign num_out  = num_ff;
   assign rem_out  = rem_ff;
   assign rad_out  = rad_ff;
endmodule
`default_nettype wire

>>> hdl/radial_gradient_pixel_unit.sv
// ----------------------------------------------------------------------------
// radial_gradient_pixel_unit: radial gradient pixel generator
// Pipeline from start to strobe: stage 0, 32 sqrt cells, 32 divide cells, fade and scale stages.
// Throughput: one pixel per cycle; busy stays low, every cell moves each cycle.
// Results cannot be stalled: rsp_valid pulses for exactly one cycle per word.
// Synchronous active-high reset clears the pipe valids and loads register
// defaults (left 0, top 0, width 1, height 1, clamp mode).
// ----------------------------------------------------------------------------
`default_nettype none
module radial_gradient_pixel_unit
   import rgp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire req_word_type  req_word,
   output logic               rsp_valid,
   output rsp_word_type       rsp_word,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_data
);
   // configuration registers
   logic [11:0] left_ff, top_ff;
   logic [12:0] width_ff, height_ff;
   logic        mode_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= 13'd1;
         height_ff <= 13'd1;
         mode_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            RegLeft:   left_ff   <= csr_data[11:0];
            RegTop:    top_ff    <= csr_data[11:0];
            RegWidth:  width_ff  <= csr_data[12:0];
            RegHeight: height_ff <= csr_data[12:0];
            RegMode:   mode_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // ---- stage 0: offsets, squared distance, radius ----
   logic [12:0] min_wh;
   logic [13:0] dx_s, dy_s;       // signed differences
   logic [12:0] adx, ady;
   logic [25:0] sqx, sqy;
   side_type    s0_in;
   side_type    s0_ff;
   logic [SqBits-1:0]  sq0_ff;
   logic [RadBits-1:0] rad0_ff;
   logic [12:0] rad_full;

   always_comb begin
      min_wh   = (width_ff < height_ff) ? width_ff : height_ff;
      rad_full = {1'b0, min_wh[12:1]};
      dx_s = {2'b00, req_word.offset_x} - {2'b00, width_ff[12:1]};
      dy_s = {2'b00, req_word.offset_y} - {2'b00, height_ff[12:1]};
      adx  = dx_s[13] ? 13'(-dx_s) : dx_s[12:0];
      ady  = dy_s[13] ? 13'(-dy_s) : dy_s[12:0];
      sqx  = adx * adx;
      sqy  = ady * ady;
      s0_in.valid    = start;
      s0_in.zero_r   = (rad_full == 13'd0);
      s0_in.mode     = mode_ff;
      s0_in.screen_x = {1'b0, left_ff} + {1'b0, req_word.offset_x};
      s0_in.screen_y = {1'b0, top_ff} + {1'b0, req_word.offset_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else begin
         s0_ff.valid <= s0_in.valid;
      end
      s0_ff.zero_r   <= s0_in.zero_r;
      s0_ff.mode     <= s0_in.mode;
      s0_ff.screen_x <= s0_in.screen_x;
      s0_ff.screen_y <= s0_in.screen_y;
      sq0_ff  <= SqBits'({6'd0, sqx} + {6'd0, sqy});
      rad0_ff <= rad_full[RadBits-1:0];
   end

   // ---- square root chain: fraction pairs shift in as zeros ----
   side_type            sq_side [SqrtCells+1];
   logic [SqBits-1:0]   sq_val  [SqrtCells+1];
   logic [RemBits-1:0]  sq_rem  [SqrtCells+1];
   logic [RootBits-1:0] sq_root [SqrtCells+1];
   logic [RadBits-1:0]  sq_rad  [SqrtCells+1];

   assign sq_side[0] = s0_ff;
   assign sq_val[0]  = sq0_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = rad0_ff;

   for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
      rgp_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .side_in  (sq_side[i]),
         .sq_in    (sq_val[i]),
         .rem_in   (sq_rem[i]),
         .root_in  (sq_root[i]),
         .rad_in   (sq_rad[i]),
         .side_out (sq_side[i+1]),
         .sq_out   (sq_val[i+1]),
         .rem_out  (sq_rem[i+1]),
         .root_out (sq_root[i+1]),
         .rad_out  (sq_rad[i+1])
      );
   end

   // ---- divide chain: root / r ----
   side_type            dv_side [DivCells+1];
   logic [RootBits-1:0] dv_num  [DivCells+1];
   logic [RadBits:0]    dv_rem  [DivCells+1];
   logic [RadBits-1:0]  dv_rad  [DivCells+1];

   assign dv_side[0] = sq_side[SqrtCells];
   assign dv_num[0]  = sq_root[SqrtCells];
   assign dv_rem[0]  = '0;
   assign dv_rad[0]  = sq_rad[SqrtCells];

   for (genvar j = 0; j < DivCells; j++) begin : g_div
      rgp_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .side_in  (dv_side[j]),
         .num_in   (dv_num[j]),
         .rem_in   (dv_rem[j]),
         .rad_in   (dv_rad[j]),
         .side_out (dv_side[j+1]),
         .num_out  (dv_num[j+1]),
         .rem_out  (dv_rem[j+1]),
         .rad_out  (dv_rad[j+1])
      );
   end

   // ---- fade stage: |one - d|, clamp or reflect select ----
   localparam logic [QuoBits:0] One = (QuoBits+1)'(1) << FracBits;
   logic [QuoBits:0]  d_ext, diff;
   logic              d_ge_one;
   side_type          f_ff;
   logic [QuoBits:0]  diff_ff;

   always_comb begin
      d_ext    = {1'b0, dv_num[DivCells]};
      d_ge_one = (d_ext >= One);
      diff     = d_ge_one ? (d_ext - One) : (One - d_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff.valid <= 1'b0;
      end else begin
         f_ff.valid <= dv_side[DivCells].valid;
      end
      f_ff.screen_x <= dv_side[DivCells].screen_x;
      f_ff.screen_y <= dv_side[DivCells].screen_y;
      f_ff.mode     <= dv_side[DivCells].mode;
      // clamp mode past the radius and zero radius both force zero
      f_ff.zero_r   <= dv_side[DivCells].zero_r | (!dv_side[DivCells].mode & d_ge_one);
      // diff above 2^(Frac+1) always saturates; keep it bounded to 18 bits
      diff_ff <= (diff > (One << 1)) ? (One << 1) : diff;
   end

   // ---- scale stage: (diff * MAX) >> FracBits, saturate, output ----
   logic [FracBits+1:0] diff_n;
   logic [FracBits+9:0] prod;
   logic [FracBits+9:0] cval;
   logic [7:0]          cbyte;

   always_comb begin
      diff_n = diff_ff[FracBits+1:0];
      prod   = diff_n * (FracBits+10)'(IntensityMax);
      cval   = prod >> FracBits;
      if (f_ff.zero_r) begin
         cbyte = 8'd0;
      end else if (cval > (FracBits+10)'(IntensityMax)) begin
         cbyte = 8'(IntensityMax);
      end else begin
         cbyte = cval[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= f_ff.valid;
      end
      rsp_word.screen_x    <= f_ff.screen_x;
      rsp_word.screen_y    <= f_ff.screen_y;
      rsp_word.blue_level  <= cbyte;
      rsp_word.green_level <= cbyte[7:1];
   end
endmodule
`default_nettype wire
